FILE: rtl/core/crtn_pkg.sv
// ----------------------------------------------------------------------------
// crtn_pkg: shared types and constants
// Widths, codes and table and divider port structures of the cumulative rate table core.
// ----------------------------------------------------------------------------
package crtn_pkg;

   localparam int NUM_LEVELS = 1024;
   localparam int NUM_MECH   = 8;
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int MECH_W     = $clog2(NUM_MECH);
   localparam int ADDR_W     = LEVEL_W + MECH_W;
   localparam int CNT_W      = 4;
   localparam int RATE_W     = 32;
   localparam int SUM_W      = 35;
   localparam int PERIOD_W   = 48;
   localparam int NORM_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int DVD_W      = SUM_W + FRAC_W;
   localparam int DIVCNT_W   = $clog2(DVD_W + 1);
   localparam int PADDR_W    = 4;
   localparam int PDATA_W    = 64;

   localparam logic [CNT_W-1:0] MECH_MAX = CNT_W'(NUM_MECH);

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_FIN   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_ZERO    = 2'd1,
      ERR_MECH    = 2'd2,
      ERR_NOT_FIN = 2'd3
   } err_type;

   typedef enum logic {
      CSR_MECH_COUNT     = 1'b0,
      CSR_DEFAULT_PERIOD = 1'b1
   } csr_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [SUM_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } tbl_req_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/crtn_req_if.sv
// ----------------------------------------------------------------------------
// crtn_req_if: request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface crtn_req_if
   import crtn_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [LEVEL_W-1:0]  level;
   logic [MECH_W-1:0]   mech;
   logic [RATE_W-1:0]   rate;

   modport source (output valid, output mode, output level, output mech, output rate,
                   input ready);
   modport sink   (input valid, input mode, input level, input mech, input rate,
                   output ready);
endinterface

FILE: rtl/core/crtn_rsp_if.sv
// ----------------------------------------------------------------------------
// crtn_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface crtn_rsp_if
   import crtn_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [NORM_W-1:0]   norm_value;
   logic [PERIOD_W-1:0] period;
   logic [1:0]          error;

   modport source (output valid, output norm_value, output period, output error,
                   input ready);
   modport sink   (input valid, input norm_value, input period, input error,
                   output ready);
endinterface

FILE: rtl/core/crtn_table.sv
// ----------------------------------------------------------------------------
// crtn_table: rate table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crtn_table
   import crtn_pkg::*;
(
   input  logic             clock,
   input  tbl_req_type      tbl_req,
   output logic [SUM_W-1:0] rdata
);
   logic [SUM_W-1:0] mem_ff [NUM_LEVELS*NUM_MECH];
   logic [SUM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.we) begin
         mem_ff[tbl_req.waddr] <= tbl_req.wdata;
      end
      if (tbl_req.re) begin
         rdata_ff <= mem_ff[tbl_req.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/crtn_div.sv
// ----------------------------------------------------------------------------
// crtn_div: restoring divider
// One quotient bit per cycle; done pulses after DVD_W steps.
// ----------------------------------------------------------------------------
module crtn_div
   import crtn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [SUM_W-1:0]    dsr_ff, dsr_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SUM_W:0]      trial;
   logic [SUM_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[SUM_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SUM_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIVCNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

FILE: rtl/core/cumulative_rate_table_normalizer_core.sv
// ----------------------------------------------------------------------------
// cumulative_rate_table_normalizer_core: rate table with cumulative normalize
// Stores raw rates per level and mechanism, turns rows into running sums on
// finalize and reports normalized Q1.16 entries on read.
// ----------------------------------------------------------------------------
//
//   channel | direction | word
//   --------+-----------+-----------------------------------------------
//   req_ch  | in        | mode, level, mech, rate (valid/ready)
//   rsp_ch  | out       | norm_value, period, error (valid/ready)
//   csr     | in        | APB: 0x0 mech_count, 0x8 default_period
//
// A write word goes straight into the table. A read word does one table
// read, then 51 steps of the shared restoring divider. Finalize walks
// every row, one table read per cycle, and writes each running sum back
// except in column 0. Reset is synchronous and clears the control state
// only; the table holds garbage until written and gets no clearing pass.
// A stalled result word is held in the output register while write words
// are still taken.
//
module cumulative_rate_table_normalizer_core
   import crtn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   crtn_req_if.sink            req_ch,
   crtn_rsp_if.source          rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_RDATA = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     mech_count_ff, mech_count_in;
   logic [PERIOD_W-1:0]  def_period_ff, def_period_in;
   logic [SUM_W-1:0]     largest_ff, largest_in;
   logic                 fin_ff, fin_in;
   logic                 op_fin_ff, op_fin_in;

   // walk issue side
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [MECH_W-1:0]    m_ff, m_in;
   // walk data side, in the cycle after the read is issued
   logic                 p_valid_ff, p_valid_in;
   logic [MECH_W-1:0]    p_m_ff, p_m_in;
   logic [ADDR_W-1:0]    p_addr_ff, p_addr_in;
   logic                 p_end_ff, p_end_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     best_ff, best_in;

   // pending result and output register
   logic [NORM_W-1:0]    pend_norm_ff, pend_norm_in;
   logic [PERIOD_W-1:0]  pend_per_ff, pend_per_in;
   err_type              pend_err_ff, pend_err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NORM_W-1:0]    rsp_norm_ff, rsp_norm_in;
   logic [PERIOD_W-1:0]  rsp_per_ff, rsp_per_in;
   logic [1:0]           rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]     used_cnt;
   logic                 req_take;
   logic                 csr_write;
   logic                 row_end;
   logic [SUM_W-1:0]     tbl_rdata;
   tbl_req_type          tbl_req;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic [DVD_W-1:0]     quo;

   crtn_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rdata   (tbl_rdata)
   );

   crtn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // mechanism counts above the table width act as the full row
   assign used_cnt  = (mech_count_ff > MECH_MAX) ? MECH_MAX : mech_count_ff;
   assign req_take  = req_ch.valid && (state_ff == ST_IDLE);
   assign csr_write = psel && penable && pwrite && pready;
   assign row_end   = ({1'b0, m_ff} == (used_cnt - 1'b1));
   assign quo       = div_rsp.quotient;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign pready       = 1'b1;
   assign prdata       = (paddr[3] == CSR_DEFAULT_PERIOD)
                         ? PDATA_W'(def_period_ff) : PDATA_W'(mech_count_ff);

   always_comb begin
      state_in      = state_ff;
      mech_count_in = mech_count_ff;
      def_period_in = def_period_ff;
      largest_in    = largest_ff;
      fin_in        = fin_ff;
      op_fin_in     = op_fin_ff;
      lvl_in        = lvl_ff;
      m_in          = m_ff;
      p_valid_in    = 1'b0;
      p_m_in        = p_m_ff;
      p_addr_in     = p_addr_ff;
      p_end_in      = p_end_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      pend_norm_in  = pend_norm_ff;
      pend_per_in   = pend_per_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_norm_in   = rsp_norm_ff;
      rsp_per_in    = rsp_per_ff;
      rsp_err_in    = rsp_err_ff;
      tbl_req       = '0;
      div_req       = '0;

      if (csr_write) begin
         if (paddr[3] == CSR_DEFAULT_PERIOD) begin
            def_period_in = pwdata[PERIOD_W-1:0];
         end else begin
            mech_count_in = pwdata[CNT_W-1:0];
         end
      end

      // fold the returning entry into the row sum, write it back past column 0
      if (p_valid_ff) begin
         acc_in = (p_m_ff == '0) ? tbl_rdata : SUM_W'(acc_ff + tbl_rdata);
         if (p_m_ff != '0) begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = p_addr_ff;
            tbl_req.wdata = acc_in;
         end
         if (p_end_ff && (acc_in > best_ff)) begin
            best_in = acc_in;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_ch.mode)
                  MODE_WRITE: begin
                     tbl_req.we    = 1'b1;
                     tbl_req.waddr = {req_ch.level, req_ch.mech};
                     tbl_req.wdata = SUM_W'(req_ch.rate);
                     fin_in        = 1'b0;
                  end
                  MODE_FIN: begin
                     op_fin_in = 1'b1;
                     fin_in    = 1'b1;
                     if (used_cnt == '0) begin
                        largest_in   = '0;
                        pend_norm_in = '0;
                        pend_per_in  = def_period_ff;
                        pend_err_in  = ERR_OK;
                        state_in     = ST_OUT;
                     end else begin
                        lvl_in   = '0;
                        m_in     = '0;
                        best_in  = '0;
                        state_in = ST_WALK;
                     end
                  end
                  MODE_READ: begin
                     op_fin_in    = 1'b0;
                     pend_norm_in = '0;
                     pend_per_in  = '0;
                     if (!fin_ff) begin
                        pend_err_in = ERR_NOT_FIN;
                        state_in    = ST_OUT;
                     end else if ({1'b0, req_ch.mech} >= used_cnt) begin
                        pend_err_in = ERR_MECH;
                        state_in    = ST_OUT;
                     end else if (largest_ff == '0) begin
                        pend_err_in = ERR_ZERO;
                        state_in    = ST_OUT;
                     end else begin
                        tbl_req.re    = 1'b1;
                        tbl_req.raddr = {req_ch.level, req_ch.mech};
                        state_in      = ST_RDATA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue one read per cycle across the used columns of each row
            tbl_req.re    = 1'b1;
            tbl_req.raddr = {lvl_ff, m_ff};
            p_valid_in    = 1'b1;
            p_m_in        = m_ff;
            p_addr_in     = {lvl_ff, m_ff};
            p_end_in      = row_end;
            if (row_end) begin
               m_in   = '0;
               lvl_in = lvl_ff + 1'b1;
               if (lvl_ff == LEVEL_W'(NUM_LEVELS - 1)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               m_in = m_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!p_valid_ff) begin
               largest_in = best_ff;
               if (best_ff == '0) begin
                  pend_norm_in = '0;
                  pend_per_in  = '0;
                  pend_err_in  = ERR_ZERO;
                  state_in     = ST_OUT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DVD_W'(1) << PERIOD_W;
                  div_req.divisor  = best_ff;
                  state_in         = ST_DIV;
               end
            end
         end
         ST_RDATA: begin
            div_req.start    = 1'b1;
            div_req.dividend = {tbl_rdata, FRAC_W'(0)};
            div_req.divisor  = largest_ff;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               pend_err_in = ERR_OK;
               if (op_fin_ff) begin
                  pend_norm_in = '0;
                  // saturate a one-unit total to the widest period
                  pend_per_in  = (quo[DVD_W-1:PERIOD_W] != '0)
                                 ? '1 : quo[PERIOD_W-1:0];
               end else begin
                  pend_per_in  = '0;
                  pend_norm_in = (quo > DVD_W'(1 << FRAC_W))
                                 ? NORM_W'(1 << FRAC_W) : quo[NORM_W-1:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_norm_in  = pend_norm_ff;
               rsp_per_in   = pend_per_ff;
               rsp_err_in   = pend_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mech_count_ff <= '0;
         def_period_ff <= '0;
         largest_ff    <= '0;
         fin_ff        <= 1'b0;
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mech_count_ff <= mech_count_in;
         def_period_ff <= def_period_in;
         largest_ff    <= largest_in;
         fin_ff        <= fin_in;
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_fin_ff    <= op_fin_in;
      lvl_ff       <= lvl_in;
      m_ff         <= m_in;
      p_m_ff       <= p_m_in;
      p_addr_ff    <= p_addr_in;
      p_end_ff     <= p_end_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      pend_norm_ff <= pend_norm_in;
      pend_per_ff  <= pend_per_in;
      pend_err_ff  <= pend_err_in;
      rsp_norm_ff  <= rsp_norm_in;
      rsp_per_ff   <= rsp_per_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.norm_value = rsp_norm_ff;
   assign rsp_ch.period     = rsp_per_ff;
   assign rsp_ch.error      = rsp_err_ff;

endmodule
